/* sv/prgb_pkg.sv */
// prgb_pkg: shared types and constants for the prewitt rgb energy map
// no dependencies
package prgb_pkg;

    localparam int unsigned MAX_HEIGHT = 4096;

    typedef struct packed {
        logic       op;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] mask_red;
        logic [7:0] mask_green;
        logic [7:0] mask_blue;
    } in_beat_t;

    typedef struct packed {
        logic [10:0] energy;
        logic        last_of_frame;
    } out_beat_t;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_MASK   = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_RED   = 2'd1,
        CLS_GREEN = 2'd2
    } mask_cls_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_SQRT,
        ST_OUT
    } state_t;

endpackage

/* sv/prgb_sqrt.sv */
// prgb_sqrt: iterative floor square root, one result bit per cycle
// depends on nothing but its ports
module prgb_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [21:0] value,
    output logic        done,
    output logic [10:0] root
);
    logic [21:0] rem_reg, rem_next;
    logic [21:0] res_reg, res_next;
    logic [21:0] bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic [21:0] trial;

    // restoring square root, one result bit per cycle
    always_comb begin
        trial     = res_reg + bit_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = value;
            res_next  = '0;
            bit_next  = 22'h100000;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_reg >= trial) begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg == 22'd1) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
        if (!aresetn) busy_reg <= 1'b0;
        else          busy_reg <= busy_next;
    end

    assign done = busy_reg && (bit_reg == 22'd1);
    assign root = res_next[10:0];
endmodule

/* sv/prewitt_rgb_energy_map_top.sv */
// Prewitt RGB energy map. One pixel beat is taken at a time; a pixel that
// completes a window runs these steps before the next beat is taken: the
// accept, nine ring memory reads, the derivative sum, loading the root unit,
// then the iterations of the bit serial square root. A result still waiting
// in the output register holds the next window before the root starts, and
// input beats stall meanwhile. A beat with no result runs none of the window
// steps. Results trail the input by frame_width+1 pixels; drain beats flush
// the tail of a frame.
// Window neighbors outside the frame clamp to the edge. Depends on prgb_pkg
// and prgb_sqrt.
module prewitt_rgb_energy_map_top
    import prgb_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_beat_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_beat_t   m_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);
    localparam int DEPTH = 2 * MAX_WIDTH + 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int PW    = $clog2(MAX_WIDTH + 3);

    // ring memories
    logic [23:0] row_mem [DEPTH];
    logic [1:0]  cls_mem [DEPTH];
    logic [23:0] rd_pix;
    logic [1:0]  rd_cls;
    logic [AW-1:0] rd_addr;
    logic        wr_en;

    // configuration
    logic [10:0] width_cfg_reg;
    logic [12:0] height_cfg_reg;
    logic        mask_reg;
    logic [WW-1:0] w_eff;
    logic [12:0] h_eff;

    // stream position
    logic [WW-1:0] col_reg, col_next;
    logic [12:0]   row_reg, row_next;
    logic [PW-1:0] pend_reg, pend_next;
    logic [WW-1:0] ocol_reg, ocol_next;
    logic [12:0]   orow_reg, orow_next;
    logic [AW-1:0] wslot_reg, wslot_next;

    state_t state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic [AW-1:0] cslot_reg, cslot_next;
    logic [23:0] win_reg [9];
    logic [1:0]  ccls_reg;
    logic [21:0] sum_reg;
    logic        last_reg, last_next;
    out_beat_t   out_reg;
    logic        ovalid_reg;

    logic        sq_start, sq_done;
    logic [10:0] sq_root;
    logic [21:0] sq_in;
    logic [44:0] q3_prod;

    always_comb begin
        if (width_cfg_reg == 11'd0) w_eff = WW'(1);
        else if (32'(width_cfg_reg) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
        else w_eff = WW'(width_cfg_reg);
        h_eff = (height_cfg_reg == 13'd0) ? 13'd1 :
                (height_cfg_reg > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : height_cfg_reg;
    end

    // input class
    mask_cls_t in_cls;
    always_comb begin
        in_cls = CLS_NONE;
        if (s_data.mask_red == 8'hff && s_data.mask_green == 8'h00 &&
            s_data.mask_blue == 8'h00) in_cls = CLS_RED;
        else if (s_data.mask_red == 8'h00 && s_data.mask_green == 8'hff &&
                 s_data.mask_blue == 8'h00) in_cls = CLS_GREEN;
    end

    // window read address: step 0..8 maps to dr, dc with edge clamp
    logic signed [15:0] off;
    logic [AW+1:0] addr_sum;
    always_comb begin
        logic [1:0] dr, dc;
        logic signed [15:0] rofs, cofs;
        case (step_reg)
            4'd0: {dr, dc} = 4'b0000;
            4'd1: {dr, dc} = 4'b0001;
            4'd2: {dr, dc} = 4'b0010;
            4'd3: {dr, dc} = 4'b0100;
            4'd4: {dr, dc} = 4'b0101;
            4'd5: {dr, dc} = 4'b0110;
            4'd6: {dr, dc} = 4'b1000;
            4'd7: {dr, dc} = 4'b1001;
            4'd8: {dr, dc} = 4'b1010;
            default: {dr, dc} = 4'b0101;
        endcase
        rofs = '0;
        cofs = '0;
        if (dr == 2'd0 && orow_reg != 13'd0) rofs = -16'(w_eff);
        if (dr == 2'd2 && orow_reg != h_eff - 13'd1) rofs = 16'(w_eff);
        if (dc == 2'd0 && ocol_reg != '0) cofs = -16'sd1;
        if (dc == 2'd2 && ocol_reg != w_eff - WW'(1)) cofs = 16'sd1;
        off = rofs + cofs;
        addr_sum = (AW+2)'(cslot_reg) + (AW+2)'(DEPTH) + (AW+2)'(off);
        if (addr_sum >= (AW+2)'(2 * DEPTH)) rd_addr = AW'(addr_sum - (AW+2)'(2 * DEPTH));
        else if (addr_sum >= (AW+2)'(DEPTH)) rd_addr = AW'(addr_sum - (AW+2)'(DEPTH));
        else rd_addr = AW'(addr_sum);
    end

    // ring memories, one write and one registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            row_mem[wslot_reg] <= {s_data.red, s_data.green, s_data.blue};
            cls_mem[wslot_reg] <= in_cls;
        end
        rd_pix <= row_mem[rd_addr];
        rd_cls <= cls_mem[rd_addr];
    end

    // prewitt sum over the captured window
    logic [21:0] psum;
    always_comb begin
        logic signed [10:0] dx, dy;
        psum = '0;
        for (int ch = 0; ch < 3; ch++) begin
            dx = '0;
            dy = '0;
            for (int k = 0; k < 3; k++) begin
                dx = dx + 11'(win_reg[k*3][16-8*ch +: 8]) - 11'(win_reg[k*3+2][16-8*ch +: 8]);
                dy = dy + 11'(win_reg[k][16-8*ch +: 8]) - 11'(win_reg[6+k][16-8*ch +: 8]);
            end
            psum = psum + 22'(dx) * 22'(dx) + 22'(dy) * 22'(dy);
        end
    end

    // divide by three through a reciprocal, exact for sums below 2^23
    assign q3_prod = 45'(sum_reg) * 45'(23'd2796203);
    assign sq_in   = mask_reg ? q3_prod[44:23] : sum_reg;

    prgb_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .value   (sq_in),
        .done    (sq_done),
        .root    (sq_root)
    );

    logic fire_in;
    assign s_ready = (state_reg == ST_IDLE);
    assign fire_in = s_valid && s_ready;
    assign m_valid = ovalid_reg;
    assign m_data  = out_reg;

    // control sequencer
    always_comb begin
        logic [AW:0] ws1;
        logic [AW+1:0] cs;
        state_next = state_reg;
        step_next  = step_reg;
        cslot_next = cslot_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        pend_next  = pend_reg;
        ocol_next  = ocol_reg;
        orow_next  = orow_reg;
        wslot_next = wslot_reg;
        last_next  = last_reg;
        wr_en      = 1'b0;
        sq_start   = 1'b0;
        ws1 = (AW+1)'(wslot_reg) + (AW+1)'(1);
        // oldest pending pixel; slot relative to the pre-increment count
        cs = (AW+2)'(wslot_reg) + (AW+2)'(DEPTH) - (AW+2)'(pend_reg);
        case (state_reg)
            ST_IDLE: begin
                if (fire_in) begin
                    if (!s_data.op) begin
                        wr_en = 1'b1;
                        wslot_next = (ws1 == (AW+1)'(DEPTH)) ? '0 : AW'(ws1);
                        if (col_reg + WW'(1) >= w_eff) begin
                            col_next = '0;
                            row_next = (row_reg + 13'd1 >= h_eff) ? 13'd0 : row_reg + 13'd1;
                        end else begin
                            col_next = col_reg + WW'(1);
                        end
                        pend_next = pend_reg + PW'(1);
                        if (32'(pend_reg) + 1 > 32'(w_eff) + 1) begin
                            state_next = ST_READ;
                            step_next  = '0;
                        end
                    end else if (row_reg == 13'd0 && col_reg == '0 && pend_reg != '0) begin
                        state_next = ST_READ;
                        step_next  = '0;
                    end
                    cslot_next = (cs >= (AW+2)'(DEPTH)) ? AW'(cs - (AW+2)'(DEPTH)) : AW'(cs);
                end
            end
            ST_READ: begin
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd9) state_next = ST_CALC;
            end
            ST_CALC: begin
                last_next = (orow_reg == h_eff - 13'd1) && (ocol_reg == w_eff - WW'(1));
                step_next = '0;
                // wait until the output register is free
                if (!ovalid_reg) state_next = ST_SQRT;
            end
            ST_SQRT: begin
                if (step_reg == 4'd0) begin
                    sq_start  = 1'b1;
                    step_next = 4'd1;
                end else if (sq_done) begin
                    state_next = ST_IDLE;
                    if (ocol_reg + WW'(1) >= w_eff) begin
                        ocol_next = '0;
                        orow_next = (orow_reg + 13'd1 >= h_eff) ? 13'd0 : orow_reg + 13'd1;
                    end else begin
                        ocol_next = ocol_reg + WW'(1);
                    end
                    pend_next = pend_reg - PW'(1);
                end
            end
            default: state_next = ST_IDLE;
        endcase
        // frame size writes restart the stream
        if (cfg_we && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT)) begin
            col_next  = '0;
            row_next  = '0;
            pend_next = '0;
            ocol_next = '0;
            orow_next = '0;
        end
    end

    // sequencer state, stream position and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            pend_reg       <= '0;
            ocol_reg       <= '0;
            orow_reg       <= '0;
            wslot_reg      <= '0;
            ovalid_reg     <= 1'b0;
            width_cfg_reg  <= 11'd1024;
            height_cfg_reg <= 13'd768;
            mask_reg       <= 1'b0;
            last_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            pend_reg  <= pend_next;
            ocol_reg  <= ocol_next;
            orow_reg  <= orow_next;
            wslot_reg <= wslot_next;
            last_reg  <= last_next;
            if (ovalid_reg && m_ready) ovalid_reg <= 1'b0;
            else if (state_reg == ST_SQRT && sq_done) ovalid_reg <= 1'b1;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_WIDTH:  width_cfg_reg <= cfg_data[10:0];
                    CFG_HEIGHT: height_cfg_reg <= cfg_data;
                    CFG_MASK:   mask_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers: window capture, sum, result
    always_ff @(posedge aclk) begin
        cslot_reg <= cslot_next;
        if (state_reg == ST_READ && step_reg != 4'd0) win_reg[step_reg - 4'd1] <= rd_pix;
        if (state_reg == ST_READ && step_reg == 4'd5) ccls_reg <= rd_cls;
        if (state_reg == ST_CALC) sum_reg <= psum;
        if (state_reg == ST_SQRT && sq_done) begin
            out_reg.last_of_frame <= last_reg;
            if (mask_reg && ccls_reg == CLS_RED) out_reg.energy <= 11'd0;
            else if (mask_reg && ccls_reg == CLS_GREEN) out_reg.energy <= 11'd255;
            else out_reg.energy <= sq_root;
        end
    end
endmodule
